/* hdl/u8dv_pkg.sv */
// ----------------------------------------------------------------------------
// u8dv_pkg: shared types and constants for the UTF-8 stream decoder
// Status codes, register indexes, decoder state and result records.
// ----------------------------------------------------------------------------
package u8dv_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_INVALID   = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	localparam logic REG_CHECK_CODE_POINTS = 1'b0;
	localparam logic REG_ALLOW_LONG_FORMS  = 1'b1;

	localparam logic [30:0] CP_MAX_UNICODE = 31'h10ffff;

	typedef struct packed {
		logic        check_code_points;
		logic        allow_long_forms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  bytes_remaining;
		logic [30:0] partial_value;
		logic [2:0]  sequence_size;
		logic        discarding;
	} dec_state_t;

	typedef struct packed {
		logic [30:0] code_point;
		status_t     status;
		logic [2:0]  sequence_length;
		logic        text_end;
	} result_t;

endpackage

/* hdl/utf8_stream_decoder_validator.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_validator: UTF-8 byte stream decoder and validator
// Path: an accepted byte request is registered in the input stage, decoded, and
// any result is written into the result queue, whose count drives out_valid.
// Throughput: one byte per cycle while in_stall is low, set by the input register
// and the two-entry result queue; in_stall rises once the queue could not take another result.
// Reset: arst_n clears decoder state and queue; check_code_points=1, long=0.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] code_point,
	output logic [1:0]  status,
	output logic [2:0]  sequence_length,
	output logic        text_end
);
	import u8dv_pkg::*;

	cfg_t       cfg_q;
	dec_state_t state_q;
	dec_state_t state_nxt;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       res_valid;
	result_t    res;
	result_t    head;
	logic [1:0] fill;
	logic [2:0] occ;
	logic       pop;
	logic       in_accept;

	assign pop       = out_valid && !out_stall;
	assign occ       = {1'b0, fill} + {2'b0, valid_s1} - {2'b0, pop};
	assign in_stall  = (occ > 3'd1);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_code_points <= 1'b1;
			cfg_q.allow_long_forms  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHECK_CODE_POINTS: cfg_q.check_code_points <= cfg_data;
				REG_ALLOW_LONG_FORMS:  cfg_q.allow_long_forms  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			valid_s1 <= in_accept;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	u8dv_decode u_decode (
		.cfg       (cfg_q),
		.state_cur (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.state_nxt (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	u8dv_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1 && res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.fill      (fill),
		.head      (head)
	);

	assign code_point      = head.code_point;
	assign status          = head.status;
	assign sequence_length = head.sequence_length;
	assign text_end        = head.text_end;

`ifndef SYNTHESIS
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> code_point == 31'd0)
		else $error("error result carries a code point");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sequence_length != 3'd0 && sequence_length != 3'd7))
		else $error("sequence length out of range");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (state_q == '0))
		else $error("state not cleared after last byte");
	a_room_for_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid) |-> (fill != 2'd2 || pop))
		else $error("decode result with no queue room");
`endif

endmodule

/* hdl/u8dv_decode.sv */
// ----------------------------------------------------------------------------
// u8dv_decode: per-byte decode step
// Next decoder state and optional result from the current state and one byte.
// ----------------------------------------------------------------------------
module u8dv_decode (
	input  u8dv_pkg::cfg_t       cfg,
	input  u8dv_pkg::dec_state_t state_cur,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output u8dv_pkg::dec_state_t state_nxt,
	output logic                 res_valid,
	output u8dv_pkg::result_t    res
);
	import u8dv_pkg::*;

	logic [2:0]  consumed;
	logic [30:0] pv_new;
	logic [2:0]  rem_new;
	logic [30:0] min_val;
	logic        bad_cp;
	logic        lead_ok;
	logic [2:0]  lead_size;
	logic [30:0] lead_bits;

	always_comb begin
		consumed = state_cur.sequence_size - state_cur.bytes_remaining + 3'd1;
		pv_new   = {state_cur.partial_value[24:0], data_byte[5:0]};
		rem_new  = state_cur.bytes_remaining - 3'd1;

		case (state_cur.sequence_size)
			3'd2:    min_val = 31'h80;
			3'd3:    min_val = 31'h800;
			3'd4:    min_val = 31'h10000;
			3'd5:    min_val = 31'h200000;
			default: min_val = 31'h4000000;
		endcase

		bad_cp = (pv_new inside {[31'hd800:31'hdfff], 31'hfffe, 31'hffff}) ||
			(!cfg.allow_long_forms && (pv_new > CP_MAX_UNICODE));

		lead_ok   = 1'b1;
		lead_size = 3'd0;
		lead_bits = '0;
		if (data_byte[7:5] == 3'b110) begin
			lead_size = 3'd2;
			lead_bits = {26'd0, data_byte[4:0]};
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_size = 3'd3;
			lead_bits = {27'd0, data_byte[3:0]};
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_size = 3'd4;
			lead_bits = {28'd0, data_byte[2:0]};
		end else if (cfg.allow_long_forms && data_byte[7:2] == 6'b111110) begin
			lead_size = 3'd5;
			lead_bits = {29'd0, data_byte[1:0]};
		end else if (cfg.allow_long_forms && data_byte[7:1] == 7'b1111110) begin
			lead_size = 3'd6;
			lead_bits = {30'd0, data_byte[0]};
		end else begin
			lead_ok = 1'b0;
		end

		state_nxt           = state_cur;
		res_valid           = 1'b0;
		res.code_point      = '0;
		res.status          = ST_OK;
		res.sequence_length = 3'd1;
		res.text_end        = last_byte;

		if (state_cur.discarding) begin
			if (last_byte) state_nxt = '0;
		end else if (state_cur.bytes_remaining == 3'd0) begin
			if (!data_byte[7]) begin
				res_valid      = 1'b1;
				res.code_point = {23'd0, data_byte};
			end else if (!lead_ok) begin
				res_valid  = 1'b1;
				res.status = ST_MALFORMED;
			end else if (last_byte) begin
				res_valid  = 1'b1;
				res.status = ST_TRUNCATED;
			end else begin
				state_nxt.sequence_size   = lead_size;
				state_nxt.bytes_remaining = lead_size - 3'd1;
				state_nxt.partial_value   = lead_bits;
			end
		end else begin
			res.sequence_length = consumed;
			if (data_byte[7:6] != 2'b10) begin
				res_valid  = 1'b1;
				res.status = ST_MALFORMED;
			end else if (rem_new == 3'd0) begin
				res_valid = 1'b1;
				if (pv_new < min_val) begin
					res.status = ST_MALFORMED;
				end else if (cfg.check_code_points && bad_cp) begin
					res.status = ST_INVALID;
				end else begin
					res.code_point = pv_new;
				end
			end else if (last_byte) begin
				res_valid  = 1'b1;
				res.status = ST_TRUNCATED;
			end else begin
				state_nxt.partial_value   = pv_new;
				state_nxt.bytes_remaining = rem_new;
			end
		end

		if (res_valid) begin
			state_nxt            = '0;
			state_nxt.discarding = (res.status != ST_OK) && !last_byte;
		end
	end

endmodule

/* hdl/u8dv_out_fifo.sv */
// ----------------------------------------------------------------------------
// u8dv_out_fifo: two-entry result queue
// Decouples the decode stage from a stalled consumer; registered outputs.
// ----------------------------------------------------------------------------
module u8dv_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8dv_pkg::result_t push_data,
	input  logic              pop,
	output logic              not_empty,
	output logic [1:0]        fill,
	output u8dv_pkg::result_t head
);
	import u8dv_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	assign not_empty = (cnt_q != 2'd0);
	assign fill      = cnt_q;
	assign head      = slot_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push || pop)
		else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0)
		else $error("result queue underflow");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");
`endif

endmodule

/* tb/sv/tb_utf8_stream_decoder_validator.sv */
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_validator: self-checking bench for the UTF-8 decoder
// Sends byte texts with random gaps and output stalls. A built-in decoder
// predicts each result, and every result is checked field by field. Directed
// texts come first, then long-form and mid-sequence register changes, then
// random texts under every register setting.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_validator;
	import u8dv_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [30:0] code_point;
	logic [1:0]  status;
	logic [2:0]  sequence_length;
	logic        text_end;

	utf8_stream_decoder_validator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_point(code_point),
		.status(status),
		.sequence_length(sequence_length),
		.text_end(text_end)
	);

	// decoder model state and registers
	logic        chk_cp;
	logic        long_ok;
	logic [2:0]  pend;
	logic [30:0] acc;
	logic [2:0]  open_size;
	logic        dropping;

	result_t     decoded_due[$];
	logic [7:0]  text_bytes[$];

	int errors;
	int cycles;
	int bytes_sent;
	int results_seen;
	int texts_sent;
	int settings_run;
	int stall_hold;
	bit idle_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				decoded_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [30:0] min_for(input logic [2:0] n);
		case (n)
			3'd2: return 31'h80;
			3'd3: return 31'h800;
			3'd4: return 31'h10000;
			3'd5: return 31'h200000;
			default: return 31'h4000000;
		endcase
	endfunction

	function automatic logic bad_cp(input logic [30:0] c);
		logic [30:0] limit;
		limit = long_ok ? 31'h7fffffff : CP_MAX_UNICODE;
		return (c >= 31'hd800 && c <= 31'hdfff) || (c >= 31'hfffe && c <= 31'hffff) ||
			c > limit;
	endfunction

	task automatic clear_decoder();
		pend = '0;
		acc = '0;
		open_size = '0;
		dropping = 1'b0;
	endtask

	task automatic post(input logic [30:0] c, input status_t s, input logic [2:0] n,
			input logic last);
		result_t r;
		r.code_point = c;
		r.status = s;
		r.sequence_length = n;
		r.text_end = last;
		decoded_due.push_back(r);
		clear_decoder();
		if (s != ST_OK && !last)
			dropping = 1'b1;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic [2:0] used;
		if (dropping) begin
			if (last)
				clear_decoder();
			return;
		end
		if (pend == 3'd0) begin
			if (!b[7]) begin
				post({24'd0, b[6:0]}, ST_OK, 3'd1, last);
				return;
			end
			if (b[7:5] == 3'b110) begin
				open_size = 3'd2;
				acc = {26'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				open_size = 3'd3;
				acc = {27'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				open_size = 3'd4;
				acc = {28'd0, b[2:0]};
			end else if (long_ok && b[7:2] == 6'b111110) begin
				open_size = 3'd5;
				acc = {29'd0, b[1:0]};
			end else if (long_ok && b[7:1] == 7'b1111110) begin
				open_size = 3'd6;
				acc = {30'd0, b[0]};
			end else begin
				post('0, ST_MALFORMED, 3'd1, last);
				return;
			end
			if (last) begin
				post('0, ST_TRUNCATED, 3'd1, last);
				return;
			end
			pend = open_size - 3'd1;
			return;
		end
		used = open_size - pend + 3'd1;
		if (b[7:6] != 2'b10) begin
			post('0, ST_MALFORMED, used, last);
			return;
		end
		acc = {acc[24:0], b[5:0]};
		pend = pend - 3'd1;
		if (pend == 3'd0) begin
			if (acc < min_for(open_size))
				post('0, ST_MALFORMED, used, last);
			else if (chk_cp && bad_cp(acc))
				post('0, ST_INVALID, used, last);
			else
				post(acc, ST_OK, used, last);
		end else if (last) begin
			post('0, ST_TRUNCATED, used, last);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got,
				want);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (decoded_due.size() == 0) begin
				report_mismatch("unrequested result, code point", {1'b0, code_point}, '0);
			end else begin
				want = decoded_due.pop_front();
				if (code_point !== want.code_point)
					report_mismatch("code_point", {1'b0, code_point}, {1'b0, want.code_point});
				if (status !== want.status)
					report_mismatch("status", {30'd0, status}, {30'd0, want.status});
				if (sequence_length !== want.sequence_length)
					report_mismatch("sequence_length", {29'd0, sequence_length},
						{29'd0, want.sequence_length});
				if (text_end !== want.text_end)
					report_mismatch("text_end", {31'd0, text_end}, {31'd0, want.text_end});
			end
		end
	end

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_hold = $urandom_range(0, 6);
		end else begin
			stall_hold = pick_gap();
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end
		end
	end

	// leaves in_valid high so back-to-back requests go out without an idle gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		texts_sent++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_CHECK_CODE_POINTS)
			chk_cp = val;
		else
			long_ok = val;
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic chk, input logic lng);
		write_reg(REG_CHECK_CODE_POINTS, chk);
		write_reg(REG_ALLOW_LONG_FORMS, lng);
		settings_run++;
	endtask

	task automatic test_basic_decoding();
		idle_on = 1'b1;
		text_bytes = '{8'h00, 8'h7f, 8'hc2, 8'h80, 8'he0, 8'ha0, 8'h80,
			8'hf4, 8'h8f, 8'hbf, 8'hbf};
		send_text();
		text_bytes = '{8'hed, 8'ha0, 8'h80};
		send_text();
		// overlong, then the rest of the text is dropped
		text_bytes = '{8'hc0, 8'h80, 8'h41, 8'h42};
		send_text();
		text_bytes = '{8'h80};
		send_text();
		text_bytes = '{8'hc2, 8'h41};
		send_text();
		text_bytes = '{8'he2, 8'h82};
		send_text();
		text_bytes = '{8'hf8};
		send_text();
	endtask

	task automatic test_long_forms_midstream();
		set_config(1'b1, 1'b1);
		text_bytes = '{8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
		send_text();
		// five-byte sequence opened with long forms on, finished with them off
		send_byte(8'hf8, 1'b0);
		write_reg(REG_ALLOW_LONG_FORMS, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b1);
		texts_sent++;
	endtask

	task automatic build_text();
		int nseq;
		int n;
		int r;
		int bits;
		int unsigned v;
		int unsigned mask;
		text_bytes.delete();
		nseq = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
		repeat (nseq) begin
			if ($urandom_range(0, 99) < 8) begin
				text_bytes.push_back(8'($urandom));
			end else begin
				r = $urandom_range(0, 9);
				n = (r < 8) ? r / 2 + 1 : r - 3;
				bits = (n == 1) ? 7 : 5 * n + 1;
				mask = (32'd1 << bits) - 1;
				case ($urandom_range(0, 9))
					0: v = (n == 1) ? 0 : min_for(3'(n));
					1: v = mask;
					2: v = (n == 1) ? $urandom : $urandom_range(0, min_for(3'(n)) - 1);
					3: begin
						case ($urandom_range(0, 8))
							0: v = 32'hd800;
							1: v = 32'hdfff;
							2: v = 32'hfffe;
							3: v = 32'hffff;
							4: v = 32'h10ffff;
							5: v = 32'h110000;
							6: v = 32'hd7ff;
							7: v = 32'he000;
							default: v = 32'hfffd;
						endcase
					end
					default: v = $urandom;
				endcase
				v = v & mask;
				if (n == 1) begin
					text_bytes.push_back({1'b0, v[6:0]});
				end else begin
					text_bytes.push_back(8'(32'hff << (8 - n)) | 8'(v >> (6 * (n - 1))));
					for (int k = n - 2; k >= 0; k--)
						text_bytes.push_back({2'b10, 6'(v >> (6 * k))});
				end
			end
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom);
		else if (r < 25 && text_bytes.size() > 1)
			void'(text_bytes.pop_back());
	endtask

	task automatic test_random_texts(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			idle_on = ($urandom_range(0, 3) != 0);
			build_text();
			send_text();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		chk_cp = 1'b1;
		long_ok = 1'b0;
		clear_decoder();
		idle_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_decoding();
		test_long_forms_midstream();
		set_config(1'b0, 1'b0);
		test_random_texts(330);
		set_config(1'b0, 1'b1);
		test_random_texts(330);
		set_config(1'b1, 1'b1);
		test_random_texts(330);
		set_config(1'b1, 1'b0);
		test_random_texts(330);
		set_config(1'($urandom), 1'($urandom));
		test_random_texts(330);

		quiesce();
		repeat (8) @(posedge clk);
		$display("covered %0d bytes in %0d texts, %0d results checked", bytes_sent,
			texts_sent, results_seen);
		$display("register settings exercised: %0d plus reset values", settings_run);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
hdl/u8dv_pkg.sv
hdl/u8dv_decode.sv
hdl/u8dv_out_fifo.sv
hdl/utf8_stream_decoder_validator.sv
tb/sv/tb_utf8_stream_decoder_validator.sv
